// ===== rtl/scb_pkg.sv =====
package scb_pkg;

  // Default sizes of the block.
  localparam int MAX_HITS_DEF       = 16;
  localparam int NUM_BARS_DEF       = 256;
  localparam int BARS_PER_PLANE_DEF = 50;

  // At most this many pairs are reported per event.
  localparam logic [6:0] MAX_PAIRS = 7'd64;

  // Serial multiplier operand and product widths.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 20;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Square root input and root widths.
  localparam int SQ_IN_W   = 40;
  localparam int SQ_ROOT_W = SQ_IN_W / 2;

  // Item modes.
  localparam logic [1:0] MODE_CAL = 2'd0;
  localparam logic [1:0] MODE_HIT = 2'd1;
  localparam logic [1:0] MODE_END = 2'd2;
  localparam logic [1:0] MODE_NOP = 2'd3;

  // Photomultiplier sides.
  localparam logic [1:0] SIDE_ONE = 2'd1;
  localparam logic [1:0] SIDE_TWO = 2'd2;

  // Configuration register indexes.
  localparam logic REG_FIRST_PLANE_HORIZ = 1'b0;
  localparam logic REG_TARGET_DISTANCE   = 1'b1;

  typedef struct packed {
    logic [1:0]         mode;
    logic [8:0]         bar_id;
    logic [1:0]         side;
    logic signed [31:0] hit_time;
    logic [15:0]        hit_charge;
    logic               cal_valid;
    logic [15:0]        cal_gain;
    logic signed [31:0] cal_offset;
    logic [15:0]        cal_speed;
  } in_item_t;

  typedef struct packed {
    logic [8:0]         pair_bar;
    logic signed [31:0] time_one;
    logic signed [31:0] time_two;
    logic signed [31:0] time_mean;
    logic [19:0]        charge_one;
    logic [19:0]        charge_two;
    logic [19:0]        charge_mean;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [30:0]        pos_z;
    logic               last;
    logic               hits_dropped;
  } out_item_t;

  // One calibration table entry.
  typedef struct packed {
    logic               valid;
    logic [15:0]        gain;
    logic signed [31:0] offset;
    logic [15:0]        speed;
  } cal_entry_t;

  // One buffered hit; side_two is clear for side 1.
  typedef struct packed {
    logic [8:0]         bar;
    logic               side_two;
    logic signed [31:0] time_raw;
    logic [15:0]        charge;
  } hit_entry_t;

  // Clamp a wide signed value to the 32-bit signed range.
  function automatic logic signed [31:0] sat32(input logic signed [MUL_P_W-1:0] v);
    logic signed [31:0] r;
    if (v > $signed(MUL_P_W'(32'h7FFF_FFFF))) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -$signed(MUL_P_W'(33'h0_8000_0000))) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/scb_ram.sv =====
module scb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/scb_mul.sv =====
module scb_mul
  import scb_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0]        b,
  output logic                      done,
  output logic signed [MUL_P_W-1:0] prod
);

  localparam int CNT_W = $clog2(MUL_B_W);

  logic                      busy;
  logic [CNT_W-1:0]          cnt;
  logic signed [MUL_A_W-1:0] areg;
  logic [MUL_B_W-1:0]        breg;
  logic signed [MUL_P_W-1:0] addend;

  // The multiplier is consumed one bit per cycle, most significant first.
  assign addend = breg[MUL_B_W-1] ? MUL_P_W'(areg) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Shift-add datapath.
  always_ff @(posedge clk) begin
    if (start) begin
      areg <= a;
      breg <= b;
      prod <= '0;
    end else if (busy) begin
      prod <= (prod <<< 1) + addend;
      breg <= breg << 1;
    end
  end

endmodule

// ===== rtl/scb_isqrt.sv =====
module scb_isqrt
  import scb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [SQ_IN_W-1:0]   v,
  output logic                 done,
  output logic [SQ_ROOT_W-1:0] root
);

  localparam int CNT_W = $clog2(SQ_ROOT_W);
  localparam int REM_W = SQ_ROOT_W + 2;

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [SQ_IN_W-1:0] vreg;
  logic [REM_W-1:0]   rem;
  logic [REM_W+1:0]   rem_sh;
  logic [REM_W+1:0]   trial;
  logic               fits;

  // Bring down two radicand bits and try the next root bit.
  assign rem_sh = {rem, vreg[SQ_IN_W-1 -: 2]};
  assign trial  = {2'b00, root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SQ_ROOT_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // One root bit per cycle.
  always_ff @(posedge clk) begin
    if (start) begin
      vreg <= v;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      vreg <= vreg << 2;
      if (fits) begin
        rem  <= REM_W'(rem_sh - trial);
        root <= {root[SQ_ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= REM_W'(rem_sh);
        root <= {root[SQ_ROOT_W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/scintillator_bar_hit_builder_core.sv =====
// Scintillator bar hit builder. Calibration entries and hits are taken one
// item per cycle while the block is idle. An end-of-event item starts a scan
// of the event buffer that pairs every calibrated side-1 hit with every
// side-2 hit of the same bar, at most 64 pairs per event, and reports one
// result item per pair, the last one marked. The scan reads the buffered
// hits one at a time, finds the plane number of each calibrated side-1 hit
// by long division, and for each pair runs four shift-add multiplies and a
// digit-by-digit square root one after another. The input stalls during
// the scan. After reset the calibration table is cleared one entry per
// cycle, all 2*NUM_BARS entries, before the first item is accepted.
module scintillator_bar_hit_builder_core
  import scb_pkg::*;
#(
  parameter int MAX_HITS       = MAX_HITS_DEF,
  parameter int NUM_BARS       = NUM_BARS_DEF,
  parameter int BARS_PER_PLANE = BARS_PER_PLANE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  in_item_t    cmd,
  output logic        res_valid,
  input  logic        res_stall,
  output out_item_t   res,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int NCH  = 2 * NUM_BARS;
  localparam int CAW  = $clog2(NCH);
  localparam int HAW  = $clog2(MAX_HITS);
  localparam int CW   = $clog2(MAX_HITS + 1);
  localparam logic [10:0] NB_LIM   = 11'(NUM_BARS);
  localparam logic [8:0]  BPP      = 9'(BARS_PER_PLANE);
  localparam logic [3:0]  DIV_LAST = 4'd8;

  // Multiplier jobs, in the order they run.
  localparam logic [1:0] JOB_Q1  = 2'd0;
  localparam logic [1:0] JOB_Q2  = 2'd1;
  localparam logic [1:0] JOB_POS = 2'd2;
  localparam logic [1:0] JOB_QQ  = 2'd3;

  typedef enum logic [14:0] {
    S_CLR     = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_I_ADDR  = 15'b000000000000100,
    S_I_DATA  = 15'b000000000001000,
    S_C1_DATA = 15'b000000000010000,
    S_DIV     = 15'b000000000100000,
    S_J_ADDR  = 15'b000000001000000,
    S_J_DATA  = 15'b000000010000000,
    S_C2_ADDR = 15'b000000100000000,
    S_C2_DATA = 15'b000001000000000,
    S_TM      = 15'b000010000000000,
    S_MSTART  = 15'b000100000000000,
    S_MWAIT   = 15'b001000000000000,
    S_SQW     = 15'b010000000000000,
    S_FINISH  = 15'b100000000000000
  } state_t;

  state_t state;

  // Configuration registers.
  logic        fph;
  logic [19:0] tdist;

  // Event buffer bookkeeping.
  logic [CW-1:0] cnt;
  logic [CW-1:0] i;
  logic [CW-1:0] j;
  logic          ovf;
  logic [6:0]    npairs;
  logic [CAW-1:0] clr_addr;

  // Memories.
  logic              cal_we;
  logic [CAW-1:0]    cal_waddr;
  cal_entry_t        cal_wdata;
  logic [CAW-1:0]    cal_raddr;
  cal_entry_t        cal_rdata;
  logic              hit_we;
  logic [HAW-1:0]    hit_raddr;
  hit_entry_t        hit_wdata;
  hit_entry_t        hit_rdata;

  // Pair datapath.
  hit_entry_t         h1;
  hit_entry_t         h2;
  cal_entry_t         cal1;
  logic [15:0]        gain2;
  logic signed [31:0] t1;
  logic signed [31:0] t2;
  logic signed [31:0] tm;
  logic signed [33:0] d;
  logic [19:0]        q1;
  logic [19:0]        q2;
  logic signed [31:0] along;
  logic [1:0]         msel;
  logic [8:0]         dvd;
  logic [7:0]         krem;
  logic [8:0]         quo;
  logic [3:0]         div_cnt;
  logic [8:0]         rem_sh;
  logic [9:0]         plane;
  logic signed [31:0] across;
  logic [31:0]        z32;
  logic signed [MUL_P_W-1:0] sum1;
  logic signed [MUL_P_W-1:0] sum2;
  logic [32:0]        tsum;

  // Arithmetic units.
  logic                      mul_start;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]        mul_b;
  logic                      mul_done;
  logic signed [MUL_P_W-1:0] mul_prod;
  logic                      sq_start;
  logic                      sq_done;
  logic [SQ_ROOT_W-1:0]      sq_root;

  // Finished pair waiting to learn whether it is the last one.
  logic      pend;
  out_item_t pend_item;
  out_item_t emit_item;
  logic      out_free;
  logic      emit;
  logic      emit_last;

  // Input decode.
  logic          cmd_take;
  logic          cmd_good;
  logic [8:0]    cmd_bar_m1;
  logic [CAW-1:0] cmd_ch;
  logic [CAW-1:0] ch1;

  assign cfg_ready = 1'b1;
  assign cmd_stall = (state != S_IDLE);
  assign cmd_take  = cmd_valid && (state == S_IDLE);
  assign cmd_good  = ({2'b00, cmd.bar_id} >= 11'd1) && ({2'b00, cmd.bar_id} <= NB_LIM) &&
                     ((cmd.side == SIDE_ONE) || (cmd.side == SIDE_TWO));
  assign cmd_bar_m1 = cmd.bar_id - 9'd1;
  assign cmd_ch     = CAW'({cmd_bar_m1, (cmd.side == SIDE_TWO)});
  assign ch1        = CAW'({9'(h1.bar - 9'd1), 1'b0});

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      fph   <= 1'b0;
      tdist <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FIRST_PLANE_HORIZ: fph   <= cfg_data[0];
        REG_TARGET_DISTANCE:   tdist <= cfg_data;
        default: ;
      endcase
    end
  end

  // Calibration table write port: clearing pass or calibration item.
  assign cal_we    = (state == S_CLR) ||
                     (cmd_take && (cmd.mode == MODE_CAL) && cmd_good);
  assign cal_waddr = (state == S_CLR) ? clr_addr : cmd_ch;
  always_comb begin
    if (state == S_CLR) begin
      cal_wdata = '0;
    end else begin
      cal_wdata.valid  = cmd.cal_valid;
      cal_wdata.gain   = cmd.cal_gain;
      cal_wdata.offset = cmd.cal_offset;
      cal_wdata.speed  = cmd.cal_speed;
    end
  end

  // Calibration read address: side-1 channel of a new hit, or side-2 channel.
  always_comb begin
    if (state == S_I_DATA) begin
      cal_raddr = CAW'({9'(hit_rdata.bar - 9'd1), 1'b0});
    end else begin
      cal_raddr = ch1 + CAW'(1);
    end
  end

  // Hit buffer ports.
  assign hit_we = cmd_take && (cmd.mode == MODE_HIT) && cmd_good &&
                  (cnt < CW'(MAX_HITS));
  assign hit_wdata.bar      = cmd.bar_id;
  assign hit_wdata.side_two = (cmd.side == SIDE_TWO);
  assign hit_wdata.time_raw = cmd.hit_time;
  assign hit_wdata.charge   = cmd.hit_charge;
  assign hit_raddr = (state == S_J_ADDR) ? j[HAW-1:0] : i[HAW-1:0];

  scb_ram #(
    .WIDTH($bits(cal_entry_t)),
    .DEPTH(NCH)
  ) u_cal_ram (
    .clk  (clk),
    .we   (cal_we),
    .waddr(cal_waddr),
    .wdata(cal_wdata),
    .raddr(cal_raddr),
    .rdata(cal_rdata)
  );

  scb_ram #(
    .WIDTH($bits(hit_entry_t)),
    .DEPTH(MAX_HITS)
  ) u_hit_ram (
    .clk  (clk),
    .we   (hit_we),
    .waddr(cnt[HAW-1:0]),
    .wdata(hit_wdata),
    .raddr(hit_raddr),
    .rdata(hit_rdata)
  );

  // Multiplier jobs: two charge scalings, the position product, the charge product.
  assign mul_start = (state == S_MSTART);
  always_comb begin
    case (msel)
      JOB_Q1: begin
        mul_a = MUL_A_W'($signed({1'b0, h1.charge}));
        mul_b = MUL_B_W'(cal1.gain);
      end
      JOB_Q2: begin
        mul_a = MUL_A_W'($signed({1'b0, h2.charge}));
        mul_b = MUL_B_W'(gain2);
      end
      JOB_POS: begin
        mul_a = d;
        mul_b = MUL_B_W'(cal1.speed);
      end
      default: begin
        mul_a = MUL_A_W'($signed({1'b0, q1}));
        mul_b = q2;
      end
    endcase
  end

  scb_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .start(mul_start),
    .a    (mul_a),
    .b    (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  assign sq_start = (state == S_MWAIT) && mul_done && (msel == JOB_QQ);

  scb_isqrt u_isqrt (
    .clk  (clk),
    .rst  (rst),
    .start(sq_start),
    .v    (mul_prod[SQ_IN_W-1:0]),
    .done (sq_done),
    .root (sq_root)
  );

  // Plane geometry from the long division of the bar index.
  assign rem_sh = {krem, dvd[8]};
  assign plane  = 10'(quo) + 10'd1;
  assign across = $signed(32'(krem) * 32'd80 + 32'd40) - 32'sd2000;
  assign z32    = 32'(plane) * 32'd80 - 32'd40 + 32'(tdist);

  // Corrected times.
  assign sum1 = MUL_P_W'(h1.time_raw) + MUL_P_W'(cal1.offset);
  assign sum2 = MUL_P_W'(h2.time_raw) + MUL_P_W'(cal_rdata.offset);
  assign tsum = 33'(t1) + 33'(t2);

  // Result hand-off.
  assign out_free  = !res_valid || !res_stall;
  assign emit      = pend && out_free && ((state == S_C2_ADDR) || (state == S_FINISH));
  assign emit_last = (state == S_FINISH);

  // The held pair with its end-of-event and overflow marks.
  always_comb begin
    emit_item              = pend_item;
    emit_item.last         = emit_last;
    emit_item.hits_dropped = ovf;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res <= emit_item;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      cnt      <= '0;
      ovf      <= 1'b0;
      i        <= '0;
      j        <= '0;
      npairs   <= '0;
      pend     <= 1'b0;
      msel     <= JOB_Q1;
      div_cnt  <= '0;
    end else begin
      unique case (state)
        S_CLR: begin
          clr_addr <= clr_addr + CAW'(1);
          if (clr_addr == CAW'(NCH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (cmd_valid) begin
            if (hit_we) begin
              cnt <= cnt + CW'(1);
            end else if ((cmd.mode == MODE_HIT) && cmd_good) begin
              ovf <= 1'b1;
            end
            if (cmd.mode == MODE_END) begin
              i      <= '0;
              npairs <= '0;
              pend   <= 1'b0;
              state  <= S_I_ADDR;
            end
          end
        end
        S_I_ADDR: begin
          state <= (i >= cnt) ? S_FINISH : S_I_DATA;
        end
        S_I_DATA: begin
          h1 <= hit_rdata;
          if (hit_rdata.side_two) begin
            i     <= i + CW'(1);
            state <= S_I_ADDR;
          end else begin
            state <= S_C1_DATA;
          end
        end
        S_C1_DATA: begin
          cal1 <= cal_rdata;
          if (!cal_rdata.valid) begin
            i     <= i + CW'(1);
            state <= S_I_ADDR;
          end else begin
            dvd     <= h1.bar - 9'd1;
            krem    <= '0;
            quo     <= '0;
            div_cnt <= '0;
            state   <= S_DIV;
          end
        end
        S_DIV: begin
          // One quotient bit per cycle.
          dvd <= dvd << 1;
          if (rem_sh >= BPP) begin
            krem <= 8'(rem_sh - BPP);
            quo  <= {quo[7:0], 1'b1};
          end else begin
            krem <= rem_sh[7:0];
            quo  <= {quo[7:0], 1'b0};
          end
          div_cnt <= div_cnt + 4'd1;
          if (div_cnt == DIV_LAST) begin
            j     <= '0;
            state <= S_J_ADDR;
          end
        end
        S_J_ADDR: begin
          if (j >= cnt) begin
            i     <= i + CW'(1);
            state <= S_I_ADDR;
          end else begin
            state <= S_J_DATA;
          end
        end
        S_J_DATA: begin
          h2 <= hit_rdata;
          if (hit_rdata.side_two && (hit_rdata.bar == h1.bar)) begin
            state <= (npairs == MAX_PAIRS) ? S_FINISH : S_C2_ADDR;
          end else begin
            j     <= j + CW'(1);
            state <= S_J_ADDR;
          end
        end
        S_C2_ADDR: begin
          // A held pair goes out first; a new pair exists, so it is not last.
          if (!pend || out_free) begin
            pend  <= 1'b0;
            state <= S_C2_DATA;
          end
        end
        S_C2_DATA: begin
          gain2 <= cal_rdata.gain;
          t1    <= sat32(sum1);
          t2    <= sat32(sum2);
          state <= S_TM;
        end
        S_TM: begin
          tm    <= tsum[32:1];
          d     <= 34'(t2) - 34'(t1);
          msel  <= JOB_Q1;
          state <= S_MSTART;
        end
        S_MSTART: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mul_done) begin
            case (msel)
              JOB_Q1:  q1    <= mul_prod[31:12];
              JOB_Q2:  q2    <= mul_prod[31:12];
              JOB_POS: along <= sat32(mul_prod >>> 10);
              default: ;
            endcase
            if (msel == JOB_QQ) begin
              state <= S_SQW;
            end else begin
              msel  <= msel + 2'd1;
              state <= S_MSTART;
            end
          end
        end
        S_SQW: begin
          if (sq_done) begin
            pend_item.pair_bar     <= h1.bar;
            pend_item.time_one     <= t1;
            pend_item.time_two     <= t2;
            pend_item.time_mean    <= tm;
            pend_item.charge_one   <= q1;
            pend_item.charge_two   <= q2;
            pend_item.charge_mean  <= sq_root;
            if (fph == plane[0]) begin
              pend_item.pos_x <= along;
              pend_item.pos_y <= across;
            end else begin
              pend_item.pos_x <= across;
              pend_item.pos_y <= along;
            end
            pend_item.pos_z        <= z32[30:0];
            pend_item.last         <= 1'b0;
            pend_item.hits_dropped <= 1'b0;
            pend   <= 1'b1;
            npairs <= npairs + 7'd1;
            j      <= j + CW'(1);
            state  <= S_J_ADDR;
          end
        end
        S_FINISH: begin
          if (!pend || out_free) begin
            pend  <= 1'b0;
            cnt   <= '0;
            ovf   <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
